// ===== rtl/sdr_pkg.sv =====
// Shared widths, constants, table lookups and hand-off types for the
// rotated-rectangle signed distance block. Depends on nothing.
package sdr_pkg;

   // Field formats
   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TAG_WIDTH    = 16;
   localparam int LEN_WIDTH    = COORD_WIDTH - 1;

   // Internal widths
   localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
   localparam int TRIG_WIDTH    = 32;
   localparam int CORDIC_WIDTH  = 34;
   localparam int ANGLE_WIDTH   = 33;
   localparam int PROD_WIDTH    = DIFF_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int ROT_SHIFT     = 29;
   localparam int LOC_WIDTH     = SUM_WIDTH - ROT_SHIFT;
   localparam int TERM_WIDTH    = LOC_WIDTH + 1;
   localparam int SQ_WIDTH      = 2 * LOC_WIDTH;
   localparam int DSQ_WIDTH     = SQ_WIDTH + 1;
   localparam int ROOT_BITS     = LOC_WIDTH;
   localparam int REM_WIDTH     = ROOT_BITS + 2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = 2;
   localparam int QCNT_WIDTH  = 3;

   // Constants
   localparam logic signed [CORDIC_WIDTH-1:0] GAIN_INV = 34'sd652032874;
   localparam logic signed [TRIG_WIDTH-1:0]   TRIG_ONE = 32'sd1073741824;
   localparam logic [LEN_WIDTH-1:0] SHORT_LIMIT =
      LEN_WIDTH'((64'd1 << FRAC_BITS) / 64'd100000);
   localparam logic [COORD_WIDTH-1:0] DIST_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   // Quadrant codes of the binary angle
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [ANGLE_WIDTH-1:0] atan_step(input int i);
      logic [31:0] a;
      case (i)
         0: a = 32'd536870912;   1: a = 32'd316933406;   2: a = 32'd167458907;
         3: a = 32'd85004756;    4: a = 32'd42667331;    5: a = 32'd21354465;
         6: a = 32'd10679838;    7: a = 32'd5340245;     8: a = 32'd2670163;
         9: a = 32'd1335087;     10: a = 32'd667544;     11: a = 32'd333772;
         12: a = 32'd166886;     13: a = 32'd83443;      14: a = 32'd41722;
         15: a = 32'd20861;      16: a = 32'd10430;      17: a = 32'd5215;
         18: a = 32'd2608;       19: a = 32'd1304;       20: a = 32'd652;
         21: a = 32'd326;        22: a = 32'd163;        23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return $signed({1'b0, a});
   endfunction

   // Request after the front: offset from the center plus cosine and sine
   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] dx;
      logic signed [DIFF_WIDTH-1:0] dy;
      logic signed [TRIG_WIDTH-1:0] co;
      logic signed [TRIG_WIDTH-1:0] si;
      logic [LEN_WIDTH-1:0]         lx;
      logic [LEN_WIDTH-1:0]         ly;
      logic [TAG_WIDTH-1:0]         tag;
   } trig_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/signed_distance_rotated_rectangle.sv =====
// Signed distance from a point to a rotated rectangle, Q16.16.
// Request channel: req_valid/req_stall with point, center, yaw, side lengths
// and a tag. Response channel: rsp_valid/rsp_stall with tag, signed distance
// and an inside flag. A transfer happens on an edge with valid high and
// stall low; one response per request, in request order.
// A request passes the CORDIC front, the queue and the back (products,
// rotation, edge terms, squares, sums, two minimum levels and a 37-digit
// square root, then the output register) on its way to a response.
// Throughput is one request per cycle while nothing stalls; every unit is
// fully pipelined.
// When rsp_stall is high while a response waits, the back pipeline holds and
// the 4-entry queue fills while the front keeps going; req_stall rises once the queue is full.
// Reset (synchronous) empties both pipelines and the queue.
// Uses sdr_pkg, sdr_front, sdr_queue and sdr_back.
module signed_distance_rotated_rectangle (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_drone_x,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_drone_y,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_center_x,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_center_y,
   input  logic [sdr_pkg::ANGLE_BITS-1:0]         req_yaw_angle,
   input  logic [sdr_pkg::LEN_WIDTH-1:0]          req_wall_length_x,
   input  logic [sdr_pkg::LEN_WIDTH-1:0]          req_wall_length_y,
   input  logic [sdr_pkg::TAG_WIDTH-1:0]          req_obstacle_tag,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sdr_pkg::TAG_WIDTH-1:0]          rsp_result_tag,
   output logic signed [sdr_pkg::COORD_WIDTH-1:0] rsp_signed_distance,
   output logic                                   rsp_inside_flag
);

   sdr_pkg::trig_item_type    front_item;
   sdr_pkg::trig_item_type    head_item;
   sdr_pkg::queue_status_type q_stat;
   logic                      front_valid;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_ready;

   // Queue takes an entry when not full or when one leaves this cycle
   assign q_ready = !q_stat.full || q_pop;
   assign q_push  = front_valid && q_ready;

   sdr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_drone_x       (req_drone_x),
      .req_drone_y       (req_drone_y),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_yaw_angle     (req_yaw_angle),
      .req_wall_length_x (req_wall_length_x),
      .req_wall_length_y (req_wall_length_y),
      .req_obstacle_tag  (req_obstacle_tag),
      .queue_ready       (q_ready),
      .item_valid        (front_valid),
      .item              (front_item)
   );

   sdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_stat)
   );

   sdr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_status        (q_stat),
      .head_item           (head_item),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_tag      (rsp_result_tag),
      .rsp_signed_distance (rsp_signed_distance),
      .rsp_inside_flag     (rsp_inside_flag)
   );

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_push && !q_pop))
      else $error("request pushed into full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.empty && q_pop))
      else $error("request popped from empty queue");

   a_inside_not_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_flag |->
         rsp_signed_distance[sdr_pkg::COORD_WIDTH-1] || rsp_signed_distance == '0)
      else $error("inside response with positive distance");
`endif

endmodule

// ===== rtl/sdr_front.sv =====
// Front part: takes requests, forms the offset to the center and runs a
// pipelined CORDIC for cosine and sine of the yaw. Uses sdr_pkg.
module sdr_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_drone_x,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_drone_y,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_center_x,
   input  logic signed [sdr_pkg::COORD_WIDTH-1:0] req_center_y,
   input  logic [sdr_pkg::ANGLE_BITS-1:0]         req_yaw_angle,
   input  logic [sdr_pkg::LEN_WIDTH-1:0]          req_wall_length_x,
   input  logic [sdr_pkg::LEN_WIDTH-1:0]          req_wall_length_y,
   input  logic [sdr_pkg::TAG_WIDTH-1:0]          req_obstacle_tag,
   input  logic                                   queue_ready,
   output logic                                   item_valid,
   output sdr_pkg::trig_item_type                 item
);

   typedef struct packed {
      logic signed [sdr_pkg::DIFF_WIDTH-1:0]   dx;
      logic signed [sdr_pkg::DIFF_WIDTH-1:0]   dy;
      logic [sdr_pkg::LEN_WIDTH-1:0]           lx;
      logic [sdr_pkg::LEN_WIDTH-1:0]           ly;
      logic [sdr_pkg::TAG_WIDTH-1:0]           tag;
      logic [1:0]                              quad;
      logic signed [sdr_pkg::CORDIC_WIDTH-1:0] x;
      logic signed [sdr_pkg::CORDIC_WIDTH-1:0] y;
      logic signed [sdr_pkg::ANGLE_WIDTH-1:0]  z;
   } cordic_stage_type;

   // One rotation of the CORDIC
   function automatic cordic_stage_type rotate_step(input cordic_stage_type s, input int i);
      cordic_stage_type r;
      logic signed [sdr_pkg::CORDIC_WIDTH-1:0] xs;
      logic signed [sdr_pkg::CORDIC_WIDTH-1:0] ys;
      r  = s;
      xs = s.y >>> i;
      ys = s.x >>> i;
      if (!s.z[sdr_pkg::ANGLE_WIDTH-1]) begin
         r.x = s.x - xs;
         r.y = s.y + ys;
         r.z = s.z - sdr_pkg::atan_step(i);
      end else begin
         r.x = s.x + xs;
         r.y = s.y - ys;
         r.z = s.z + sdr_pkg::atan_step(i);
      end
      return r;
   endfunction

   function automatic logic signed [sdr_pkg::TRIG_WIDTH-1:0] clamp_trig(
      input logic signed [sdr_pkg::CORDIC_WIDTH-1:0] v);
      logic signed [sdr_pkg::CORDIC_WIDTH-1:0] one;
      one = sdr_pkg::CORDIC_WIDTH'(sdr_pkg::TRIG_ONE);
      if (v > one) return sdr_pkg::TRIG_ONE;
      else if (v < -one) return -sdr_pkg::TRIG_ONE;
      else return sdr_pkg::TRIG_WIDTH'(v);
   endfunction

   cordic_stage_type                 cs_ff [0:sdr_pkg::CORDIC_STEPS];
   logic [sdr_pkg::CORDIC_STEPS:0]   vld_ff;
   logic [31:0]                      z32;
   logic                             advance;
   logic signed [sdr_pkg::TRIG_WIDTH-1:0] cx;
   logic signed [sdr_pkg::TRIG_WIDTH-1:0] cy;

   // The whole pipeline moves whenever the queue can take its last entry
   assign advance   = queue_ready;
   assign req_stall = !advance;
   assign z32       = 32'(req_yaw_angle) << (32 - sdr_pkg::ANGLE_BITS);

   // Track occupied stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[sdr_pkg::CORDIC_STEPS-1:0], req_valid};
      end
   end

   // Load the request: offset, quadrant and start vector
   always_ff @(posedge clock) begin
      if (advance) begin
         cs_ff[0].dx   <= sdr_pkg::DIFF_WIDTH'(req_drone_x) - sdr_pkg::DIFF_WIDTH'(req_center_x);
         cs_ff[0].dy   <= sdr_pkg::DIFF_WIDTH'(req_drone_y) - sdr_pkg::DIFF_WIDTH'(req_center_y);
         cs_ff[0].lx   <= req_wall_length_x;
         cs_ff[0].ly   <= req_wall_length_y;
         cs_ff[0].tag  <= req_obstacle_tag;
         cs_ff[0].quad <= z32[31:30];
         cs_ff[0].x    <= sdr_pkg::GAIN_INV;
         cs_ff[0].y    <= '0;
         cs_ff[0].z    <= $signed(sdr_pkg::ANGLE_WIDTH'(z32[29:0]));
      end
   end

   // Advance the CORDIC stages
   for (genvar k = 0; k < sdr_pkg::CORDIC_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            cs_ff[k+1] <= rotate_step(cs_ff[k], k);
         end
      end
   end

   // Clamp and map the quadrant
   assign cx = clamp_trig(cs_ff[sdr_pkg::CORDIC_STEPS].x);
   assign cy = clamp_trig(cs_ff[sdr_pkg::CORDIC_STEPS].y);

   always_comb begin
      item.dx  = cs_ff[sdr_pkg::CORDIC_STEPS].dx;
      item.dy  = cs_ff[sdr_pkg::CORDIC_STEPS].dy;
      item.lx  = cs_ff[sdr_pkg::CORDIC_STEPS].lx;
      item.ly  = cs_ff[sdr_pkg::CORDIC_STEPS].ly;
      item.tag = cs_ff[sdr_pkg::CORDIC_STEPS].tag;
      unique case (cs_ff[sdr_pkg::CORDIC_STEPS].quad)
         sdr_pkg::QUAD_1: begin item.co = -cy; item.si = cx;  end
         sdr_pkg::QUAD_2: begin item.co = -cx; item.si = -cy; end
         sdr_pkg::QUAD_3: begin item.co = cy;  item.si = -cx; end
         default:         begin item.co = cx;  item.si = cy;  end
      endcase
   end

   assign item_valid = vld_ff[sdr_pkg::CORDIC_STEPS];

endmodule

// ===== rtl/sdr_queue.sv =====
// Short queue between front and back so each side stalls on its own.
// Uses sdr_pkg for the entry type and depth.
module sdr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sdr_pkg::trig_item_type    push_item,
   input  logic                      pop,
   output sdr_pkg::trig_item_type    head_item,
   output sdr_pkg::queue_status_type status
);

   sdr_pkg::trig_item_type             entry_ff [0:sdr_pkg::QUEUE_DEPTH-1];
   logic [sdr_pkg::QPTR_WIDTH-1:0]     wr_ptr_ff;
   logic [sdr_pkg::QPTR_WIDTH-1:0]     rd_ptr_ff;
   logic [sdr_pkg::QCNT_WIDTH-1:0]     count_ff;
   logic [sdr_pkg::QCNT_WIDTH-1:0]     count_in;

   // Store a request
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == sdr_pkg::QCNT_WIDTH'(sdr_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/sdr_back.sv =====
// Back part: rotates the offset into the rectangle frame, measures the distance to
// each edge, takes the least and runs a pipelined square root. Uses sdr_pkg.
module sdr_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sdr_pkg::queue_status_type              queue_status,
   input  sdr_pkg::trig_item_type                 head_item,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sdr_pkg::TAG_WIDTH-1:0]          rsp_result_tag,
   output logic signed [sdr_pkg::COORD_WIDTH-1:0] rsp_signed_distance,
   output logic                                   rsp_inside_flag
);

   localparam int RB = sdr_pkg::ROOT_BITS;
   localparam int NV = 8 + RB;
   localparam logic signed [sdr_pkg::SUM_WIDTH-1:0] ROT_ROUND =
      sdr_pkg::SUM_WIDTH'(1) << (sdr_pkg::ROT_SHIFT - 1);

   typedef struct packed {
      logic signed [sdr_pkg::PROD_WIDTH-1:0] xc;
      logic signed [sdr_pkg::PROD_WIDTH-1:0] ys;
      logic signed [sdr_pkg::PROD_WIDTH-1:0] xs;
      logic signed [sdr_pkg::PROD_WIDTH-1:0] yc;
      logic [sdr_pkg::LEN_WIDTH-1:0]         lx;
      logic [sdr_pkg::LEN_WIDTH-1:0]         ly;
      logic [sdr_pkg::TAG_WIDTH-1:0]         tag;
   } prod_stage_type;

   typedef struct packed {
      logic signed [sdr_pkg::LOC_WIDTH-1:0] x;
      logic signed [sdr_pkg::LOC_WIDTH-1:0] y;
      logic [sdr_pkg::LEN_WIDTH-1:0]        lx;
      logic [sdr_pkg::LEN_WIDTH-1:0]        ly;
      logic [sdr_pkg::TAG_WIDTH-1:0]        tag;
   } local_stage_type;

   typedef struct packed {
      logic [7:0][sdr_pkg::LOC_WIDTH-1:0] m;
      logic                               in_rect;
      logic [sdr_pkg::TAG_WIDTH-1:0]      tag;
   } term_stage_type;

   typedef struct packed {
      logic [7:0][sdr_pkg::SQ_WIDTH-1:0] q;
      logic                              in_rect;
      logic [sdr_pkg::TAG_WIDTH-1:0]     tag;
   } square_stage_type;

   typedef struct packed {
      logic [3:0][sdr_pkg::DSQ_WIDTH-1:0] d;
      logic                               in_rect;
      logic [sdr_pkg::TAG_WIDTH-1:0]      tag;
   } sum_stage_type;

   typedef struct packed {
      logic [1:0][sdr_pkg::DSQ_WIDTH-1:0] d;
      logic                               in_rect;
      logic [sdr_pkg::TAG_WIDTH-1:0]      tag;
   } pair_stage_type;

   typedef struct packed {
      logic [sdr_pkg::SQ_WIDTH-1:0]  t;
      logic [1:0]                    e;
      logic [sdr_pkg::REM_WIDTH-1:0] rem;
      logic [RB-1:0]                 root;
      logic                          in_rect;
      logic [sdr_pkg::TAG_WIDTH-1:0] tag;
   } sqrt_stage_type;

   function automatic logic signed [sdr_pkg::TERM_WIDTH-1:0] excess(
      input logic signed [sdr_pkg::LOC_WIDTH-1:0]  v,
      input logic signed [sdr_pkg::TERM_WIDTH-1:0] h);
      logic signed [sdr_pkg::TERM_WIDTH-1:0] ve;
      ve = sdr_pkg::TERM_WIDTH'(v);
      if (ve > h) return ve - h;
      else if (ve < -h) return ve + h;
      else return '0;
   endfunction

   function automatic logic [sdr_pkg::LOC_WIDTH-1:0] magnitude(
      input logic signed [sdr_pkg::TERM_WIDTH-1:0] v);
      logic [sdr_pkg::TERM_WIDTH-1:0] a;
      a = v[sdr_pkg::TERM_WIDTH-1] ? -v : v;
      return a[sdr_pkg::LOC_WIDTH-1:0];
   endfunction

   function automatic logic [sdr_pkg::DSQ_WIDTH-1:0] min2(
      input logic [sdr_pkg::DSQ_WIDTH-1:0] a,
      input logic [sdr_pkg::DSQ_WIDTH-1:0] b);
      return (b < a) ? b : a;
   endfunction

   // One digit of the restoring square root
   function automatic sqrt_stage_type root_step(input sqrt_stage_type s, input int k);
      sqrt_stage_type r;
      logic [sdr_pkg::REM_WIDTH+1:0] ts;
      logic [sdr_pkg::REM_WIDTH+1:0] trial;
      r     = s;
      ts    = {s.rem, s.t[sdr_pkg::SQ_WIDTH-1-2*k -: 2]};
      trial = (sdr_pkg::REM_WIDTH+2)'({s.root, 2'b01});
      if (ts >= trial) begin
         r.rem  = sdr_pkg::REM_WIDTH'(ts - trial);
         r.root = {s.root[RB-2:0], 1'b1};
      end else begin
         r.rem  = sdr_pkg::REM_WIDTH'(ts);
         r.root = {s.root[RB-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [NV-1:0]    v_ff;
   logic             advance;
   prod_stage_type   b1_ff;
   local_stage_type  b2_ff;
   term_stage_type   b3_ff;
   square_stage_type b4_ff;
   sum_stage_type    b5_ff;
   pair_stage_type   b6_ff;
   sqrt_stage_type   sq_ff [0:RB];

   logic signed [sdr_pkg::SUM_WIDTH-1:0]  sum_x;
   logic signed [sdr_pkg::SUM_WIDTH-1:0]  sum_y;
   logic signed [sdr_pkg::TERM_WIDTH-1:0] xe;
   logic signed [sdr_pkg::TERM_WIDTH-1:0] ye;
   logic signed [sdr_pkg::TERM_WIDTH-1:0] sx;
   logic signed [sdr_pkg::TERM_WIDTH-1:0] sy;
   logic                                  short_x;
   logic                                  short_y;
   logic [sdr_pkg::DSQ_WIDTH-1:0]         best;
   logic                                  round_up;
   logic [RB:0]                           rounded;
   logic [sdr_pkg::COORD_WIDTH-1:0]       dist_mag;

   // Stall the whole back pipeline only when the result waits
   assign advance = !v_ff[NV-1] || !rsp_stall;
   assign pop     = advance && !queue_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[NV-2:0], pop};
      end
   end

   // Multiply offset by cosine and sine
   always_ff @(posedge clock) begin
      if (advance) begin
         b1_ff.xc  <= sdr_pkg::PROD_WIDTH'(head_item.dx) * sdr_pkg::PROD_WIDTH'(head_item.co);
         b1_ff.ys  <= sdr_pkg::PROD_WIDTH'(head_item.dy) * sdr_pkg::PROD_WIDTH'(head_item.si);
         b1_ff.xs  <= sdr_pkg::PROD_WIDTH'(head_item.dx) * sdr_pkg::PROD_WIDTH'(head_item.si);
         b1_ff.yc  <= sdr_pkg::PROD_WIDTH'(head_item.dy) * sdr_pkg::PROD_WIDTH'(head_item.co);
         b1_ff.lx  <= head_item.lx;
         b1_ff.ly  <= head_item.ly;
         b1_ff.tag <= head_item.tag;
      end
   end

   // Round to doubled local coordinates
   assign sum_x = sdr_pkg::SUM_WIDTH'(b1_ff.xc) + sdr_pkg::SUM_WIDTH'(b1_ff.ys) + ROT_ROUND;
   assign sum_y = sdr_pkg::SUM_WIDTH'(b1_ff.yc) - sdr_pkg::SUM_WIDTH'(b1_ff.xs) + ROT_ROUND;

   always_ff @(posedge clock) begin
      if (advance) begin
         b2_ff.x   <= sum_x[sdr_pkg::SUM_WIDTH-1:sdr_pkg::ROT_SHIFT];
         b2_ff.y   <= sum_y[sdr_pkg::SUM_WIDTH-1:sdr_pkg::ROT_SHIFT];
         b2_ff.lx  <= b1_ff.lx;
         b2_ff.ly  <= b1_ff.ly;
         b2_ff.tag <= b1_ff.tag;
      end
   end

   // Form the edge offsets of the four segments
   assign xe      = sdr_pkg::TERM_WIDTH'(b2_ff.x);
   assign ye      = sdr_pkg::TERM_WIDTH'(b2_ff.y);
   assign sx      = $signed(sdr_pkg::TERM_WIDTH'(b2_ff.lx));
   assign sy      = $signed(sdr_pkg::TERM_WIDTH'(b2_ff.ly));
   assign short_x = (b2_ff.lx <= sdr_pkg::SHORT_LIMIT);
   assign short_y = (b2_ff.ly <= sdr_pkg::SHORT_LIMIT);

   always_ff @(posedge clock) begin
      if (advance) begin
         b3_ff.m[0] <= magnitude(short_x ? xe + sx : excess(b2_ff.x, sx));
         b3_ff.m[1] <= magnitude(ye - sy);
         b3_ff.m[2] <= magnitude(xe - sx);
         b3_ff.m[3] <= magnitude(short_y ? ye - sy : excess(b2_ff.y, sy));
         b3_ff.m[4] <= magnitude(short_x ? xe - sx : excess(b2_ff.x, sx));
         b3_ff.m[5] <= magnitude(ye + sy);
         b3_ff.m[6] <= magnitude(xe + sx);
         b3_ff.m[7] <= magnitude(short_y ? ye + sy : excess(b2_ff.y, sy));
         b3_ff.in_rect <= (xe > -sx) && (xe < sx) && (ye > -sy) && (ye < sy);
         b3_ff.tag     <= b2_ff.tag;
      end
   end

   // Square each offset
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 8; i++) begin
            b4_ff.q[i] <= sdr_pkg::SQ_WIDTH'(b3_ff.m[i]) * sdr_pkg::SQ_WIDTH'(b3_ff.m[i]);
         end
         b4_ff.in_rect <= b3_ff.in_rect;
         b4_ff.tag     <= b3_ff.tag;
      end
   end

   // Sum to squared segment distances
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            b5_ff.d[i] <= sdr_pkg::DSQ_WIDTH'(b4_ff.q[2*i]) +
                          sdr_pkg::DSQ_WIDTH'(b4_ff.q[2*i+1]);
         end
         b5_ff.in_rect <= b4_ff.in_rect;
         b5_ff.tag     <= b4_ff.tag;
      end
   end

   // Reduce pairwise
   always_ff @(posedge clock) begin
      if (advance) begin
         b6_ff.d[0]    <= min2(b5_ff.d[0], b5_ff.d[1]);
         b6_ff.d[1]    <= min2(b5_ff.d[2], b5_ff.d[3]);
         b6_ff.in_rect <= b5_ff.in_rect;
         b6_ff.tag     <= b5_ff.tag;
      end
   end

   // Take the least and seed the root on a quarter of it
   assign best = min2(b6_ff.d[0], b6_ff.d[1]);

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff[0].t       <= sdr_pkg::SQ_WIDTH'(best >> 2);
         sq_ff[0].e       <= best[1:0];
         sq_ff[0].rem     <= '0;
         sq_ff[0].root    <= '0;
         sq_ff[0].in_rect <= b6_ff.in_rect;
         sq_ff[0].tag     <= b6_ff.tag;
      end
   end

   for (genvar k = 0; k < RB; k++) begin : g_root
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_ff[k+1] <= root_step(sq_ff[k], k);
         end
      end
   end

   // Round half of the root, saturate and apply the sign
   assign round_up = {sq_ff[RB].rem, sq_ff[RB].e} >
                     (sdr_pkg::REM_WIDTH+2)'({sq_ff[RB].root, 2'b00});
   assign rounded  = (RB+1)'(sq_ff[RB].root) + (RB+1)'(round_up);
   assign dist_mag = (rounded > (RB+1)'(sdr_pkg::DIST_MAX)) ? sdr_pkg::DIST_MAX :
                     sdr_pkg::COORD_WIDTH'(rounded);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_tag      <= sq_ff[RB].tag;
         rsp_inside_flag     <= sq_ff[RB].in_rect;
         rsp_signed_distance <= sq_ff[RB].in_rect ? -$signed(dist_mag) : $signed(dist_mag);
      end
   end

   assign rsp_valid = v_ff[NV-1];

endmodule

// ===== bench/signed_distance_rotated_rectangle_tb.sv =====
// Testbench for the rotated-rectangle signed distance block: directed and
// random requests, a bit-exact predictor and an in-order scoreboard.
// Depends on sdr_pkg and signed_distance_rotated_rectangle.
module signed_distance_rotated_rectangle_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sdr_pkg::*;

   localparam int RANDOM_REQUESTS = 930;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 80;
   localparam logic signed [31:0] CORDIC_GAIN_START = 32'sd652032874;

   typedef struct {
      logic [15:0]        tag;
      logic signed [31:0] distance;
      logic               in_rect;
   } distance_result_type;

   typedef struct {
      logic signed [31:0] px, py, cx, cy;
      logic [15:0]        yaw;
      logic [30:0]        lx, ly;
      logic [15:0]        tag;
   } obstacle_request_type;

   // Per-quadrant CORDIC; returns cosine and sine in Q2.30
   function automatic void cordic_sin_cos(input logic [15:0] yaw,
         output longint co, output longint si);
      logic [31:0] z32;
      longint x, y, z, tx, ty;
      z32 = {yaw, 16'd0};
      x = CORDIC_GAIN_START;
      y = 0;
      z = longint'(z32[29:0]);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         tx = y >>> i;
         ty = x >>> i;
         if (z >= 0) begin
            x = x - tx; y = y + ty; z = z - longint'(atan_step(i));
         end else begin
            x = x + tx; y = y - ty; z = z + longint'(atan_step(i));
         end
      end
      if (x > longint'(TRIG_ONE)) x = TRIG_ONE;
      if (x < -longint'(TRIG_ONE)) x = -longint'(TRIG_ONE);
      if (y > longint'(TRIG_ONE)) y = TRIG_ONE;
      if (y < -longint'(TRIG_ONE)) y = -longint'(TRIG_ONE);
      case (z32[31:30])
         QUAD_1: begin co = -y; si = x; end
         QUAD_2: begin co = -x; si = -y; end
         QUAD_3: begin co = y; si = -x; end
         default: begin co = x; si = y; end
      endcase
   endfunction

   function automatic longint edge_excess(longint v, longint h);
      if (v > h) return v - h;
      if (v < -h) return v + h;
      return 0;
   endfunction

   function automatic logic [127:0] square_sum(longint a, longint b);
      logic signed [127:0] wa, wb;
      wa = a;
      wb = b;
      return wa * wa + wb * wb;
   endfunction

   // Bit-exact distance prediction for one request
   function automatic distance_result_type predict_distance(obstacle_request_type r);
      distance_result_type res;
      longint co, si, dx, dy, sx, sy, xl, yl;
      logic signed [127:0] acc;
      logic [127:0] d [4];
      logic [127:0] best, t;
      logic [63:0] root, c;
      logic short_x, short_y, ins;
      cordic_sin_cos(r.yaw, co, si);
      dx = longint'(r.px) - longint'(r.cx);
      dy = longint'(r.py) - longint'(r.cy);
      acc = 128'(dx) * 128'(co) + 128'(dy) * 128'(si) + (128'sd1 <<< 28);
      xl = longint'(acc >>> 29);
      acc = 128'(-dx) * 128'(si) + 128'(dy) * 128'(co) + (128'sd1 <<< 28);
      yl = longint'(acc >>> 29);
      sx = longint'(r.lx);
      sy = longint'(r.ly);
      short_x = r.lx <= SHORT_LIMIT;
      short_y = r.ly <= SHORT_LIMIT;
      ins = xl > -sx && xl < sx && yl > -sy && yl < sy;
      d[0] = square_sum(short_x ? xl + sx : edge_excess(xl, sx), yl - sy);
      d[1] = square_sum(xl - sx, short_y ? yl - sy : edge_excess(yl, sy));
      d[2] = square_sum(short_x ? xl - sx : edge_excess(xl, sx), yl + sy);
      d[3] = square_sum(xl + sx, short_y ? yl + sy : edge_excess(yl, sy));
      best = d[0];
      for (int k = 1; k < 4; k++)
         if (d[k] < best) best = d[k];
      t = best >> 2;
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         c = root | (64'd1 << b);
         if (128'(c) * 128'(c) <= t) root = c;
      end
      if (best > 128'(root << 2) * 128'(root + 64'd1)) root++;
      if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
      res.tag = r.tag;
      res.distance = ins ? -$signed(root[31:0]) : $signed(root[31:0]);
      res.in_rect = ins;
      return res;
   endfunction

   class distance_scoreboard;
      distance_result_type pending[$];
      int mismatches;

      function void note_request(obstacle_request_type r);
         pending = {pending, predict_distance(r)};
      endfunction

      function void check_response(distance_result_type got);
         distance_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response tag=%h dist=%0d", got.tag, got.distance);
            return;
         end
         want = pending.pop_front();
         if (got.tag !== want.tag || got.distance !== want.distance ||
               got.in_rect !== want.in_rect) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected tag=%h dist=%0d in=%b, got tag=%h dist=%0d in=%b",
                  want.tag, want.distance, want.in_rect, got.tag, got.distance, got.in_rect);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_inside_flag;
   logic signed [31:0] req_drone_x, req_drone_y, req_center_x, req_center_y;
   logic [15:0] req_yaw_angle, req_obstacle_tag, rsp_result_tag;
   logic [30:0] req_wall_length_x, req_wall_length_y;
   logic signed [31:0] rsp_signed_distance;
   distance_scoreboard board;
   int idle_cycles;

   signed_distance_rotated_rectangle DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watch accepted traffic, check responses and stop on a stuck handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response('{rsp_result_tag, rsp_signed_distance, rsp_inside_flag});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Stall the response side in a pattern of its own
   initial begin
      int mode;
      rsp_stall = 0;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Present one request and hold it until accepted
   task automatic send_request(obstacle_request_type r);
      req_valid <= 1;
      req_drone_x <= r.px;
      req_drone_y <= r.py;
      req_center_x <= r.cx;
      req_center_y <= r.cy;
      req_yaw_angle <= r.yaw;
      req_wall_length_x <= r.lx;
      req_wall_length_y <= r.ly;
      req_obstacle_tag <= r.tag;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(0, 4))
         0: return $signed($urandom());
         1: return $signed(32'($urandom_range(0, 20000000)) - 32'sd10000000);
         default: return $signed(32'($urandom_range(0, 4000000)) - 32'sd2000000);
      endcase
   endfunction

   function automatic logic [30:0] random_length();
      case ($urandom_range(0, 5))
         0: return 31'($urandom());
         1: return 31'($urandom_range(0, 1));
         default: return 31'($urandom_range(0, 3000000));
      endcase
   endfunction

   function automatic obstacle_request_type random_request();
      obstacle_request_type r;
      r.cx = random_coord();
      r.cy = random_coord();
      // Mostly points near the obstacle so inside and edge cases are common
      if ($urandom_range(0, 2) != 0) begin
         r.px = r.cx + $signed(32'($urandom_range(0, 4000000)) - 32'sd2000000);
         r.py = r.cy + $signed(32'($urandom_range(0, 4000000)) - 32'sd2000000);
      end else begin
         r.px = random_coord();
         r.py = random_coord();
      end
      r.yaw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) << 14) : 16'($urandom());
      r.lx = random_length();
      r.ly = random_length();
      r.tag = 16'($urandom());
      return r;
   endfunction

   initial begin
      obstacle_request_type r;
      board = new();
      idle_cycles = 0;
      reset = 1;
      req_valid = 0;
      req_drone_x = 0; req_drone_y = 0; req_center_x = 0; req_center_y = 0;
      req_yaw_angle = 0; req_wall_length_x = 0; req_wall_length_y = 0;
      req_obstacle_tag = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extremes, boundary, zero and short sides, each quadrant
      send_request('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd131072, 31'd65536, 16'h0000});
      send_request('{32'sd131072, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd131072, 31'd65536, 16'h0001});
      send_request('{32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 16'd16384, 31'd0, 31'd0, 16'h0002});
      send_request('{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'd0, 31'd131072, 16'h0003});
      send_request('{32'sd100, 32'sd300, 32'sd0, 32'sd0, 16'd0, 31'd0, 31'd1, 16'h0004});
      send_request('{32'sd100, 32'sd300, 32'sd0, 32'sd0, 16'd0, 31'd1, 31'd0, 16'h0005});
      send_request('{32'sd100, 32'sd300, 32'sd0, 32'sd0, 16'd0, 31'd2, 31'd2, 16'h0006});
      send_request('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
         16'd8192, 31'd0, 31'd0, 16'hFFFF});
      send_request('{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
         16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'hA5A5});
      send_request('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 16'h5A5A});
      for (int q = 0; q < 4; q++) begin
         send_request('{32'sd200000, -32'sd70000, 32'sd1000, 32'sd3000,
            16'(q * 16384), 31'd300000, 31'd90000, 16'(16'h10 + q)});
         send_request('{32'sd30000, -32'sd20000, 32'sd0, 32'sd0,
            16'(q * 16384 + 5000), 31'd300000, 31'd90000, 16'(16'h20 + q)});
      end
      send_request('{32'sh55555555, 32'shAAAAAAAA, 32'sh33333333, 32'shCCCCCCCC,
         16'h5555, 31'h2AAAAAAA, 31'h55555555, 16'h3C3C});

      // Let everything drain once before the random part
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);

      // Random bursts with random gaps, some runs back to back
      for (int n = 0; n < RANDOM_REQUESTS; ) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < RANDOM_REQUESTS; b++, n++) begin
            r = random_request();
            send_request(r);
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
      end
      req_valid <= 0;

      // Drain, then allow the pipeline latency to expose stray responses
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
